[hw/rtl/lcfq_pkg.sv]
// Package for the camera-facing line ribbon expander.
// Holds the payload word types, the carried stage record and the register indexes.
// No dependencies.
package lcfq_pkg;

  localparam int COORD_W    = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int HN_W       = 57;
  localparam int LEN_W      = 31;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_CAM_X = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CAM_Y = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CAM_Z = 2'd2;

  // Last position of the six-vertex triangle list.
  localparam logic [2:0] SLOT_LAST = 3'd5;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
    logic        [COORD_W-1:0] raw_width;
    logic        [COORD_W-1:0] color;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
    logic        [COORD_W-1:0] vertex_color;
    logic        [2:0]         corner_slot;
    logic                      degenerate;
    logic                      last;
  } out_word_t;

  // Record that travels alongside the arithmetic down the pipeline.
  typedef struct packed {
    logic [2:0][COORD_W-1:0] pt_a;
    logic [2:0][COORD_W-1:0] pt_b;
    logic [COORD_W-1:0]      color;
    logic [COORD_W-1:0]      half;
    logic                    degen;
    logic [2:0][HN_W-1:0]    hn;
    logic [2:0]              neg;
    logic [LEN_W-1:0]        len;
  } carry_t;

endpackage

[hw/rtl/line_to_camera_facing_quad.sv]
// Camera-facing line ribbon expander, top level.
// Depends on lcfq_pkg for the payload words, the stage record and register indexes.
//
// How to use this block:
// Each input word on in_valid/in_ready is one 3D line segment (two signed
// fixed-point endpoints), a raw width and a packed colour. The block turns
// the segment into a flat ribbon facing the camera position held in the
// three cfg_ registers, and sends six output words on out_valid/out_ready,
// one vertex per word, in the order A1, A2, B1, A2, B2, B1. The sixth word
// carries last. Camera registers are written with cfg_we, cfg_addr and
// cfg_wdata while the block is idle; a write to an unused index is dropped.
// The datapath is a 67-stage pipeline: range scaling, cross product, normal
// scaling, a one-bit-per-stage square root and a one-bit-per-stage divider.
// A segment's first vertex is offered once it passes the last stage into the
// serialiser. A new word can enter in every cycle unless the pipeline freezes,
// but the output serialiser limits the rate to one segment per six words.
// While the serialiser still has words of one segment to send and the last
// stage holds the next segment, the whole pipeline freezes, so a stalled
// receiver backs up into in_ready and nothing is lost or repeated.
// Reset clears all valid bits and the camera registers to zero; there is
// no clearing pass, and the block takes words in the first cycle after reset.
module line_to_camera_facing_quad
  import lcfq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [COORD_W-1:0]    cfg_wdata
);

  // Stage numbering: register stage k holds the results of step k.
  localparam int ST_SHR = 1;  // range scaling of d and v, reciprocal product
  localparam int ST_PRD = 2;  // cross-product partial products, half width fixed
  localparam int ST_CRS = 3;  // normal components
  localparam int ST_ENC = 4;  // normal scaling amount
  localparam int ST_NRM = 5;  // scaled normal
  localparam int ST_SQR = 6;  // squares and normal times half width
  localparam int ST_SUM = 7;  // sum of squares
  localparam int ST_SQ0 = 8;  // first square-root step
  localparam int SQ_N   = 31;
  localparam int ST_NUM = ST_SQ0 + SQ_N;  // rounded numerators
  localparam int ST_DV0 = ST_NUM + 1;     // first divider step
  localparam int DV_N   = 26;
  localparam int ST_VTX = ST_DV0 + DV_N;  // four corner points
  localparam int NST    = ST_VTX + 1;

  localparam int D_W    = COORD_W + 1;
  localparam int VEC_W  = 31;
  localparam int PRD_W  = 62;
  localparam int CRS_W  = 63;
  localparam int SH_W   = 6;
  localparam int SQ_W   = 62;
  localparam int REM_W  = 35;
  localparam int HALF_W = 25;
  localparam int NUM_W  = 58;
  localparam int Q_W    = 26;
  localparam int S_W    = COORD_W + 2;

  // Width / 150 is done as ((width + 75) >> 1) / 75 by reciprocal multiply.
  localparam logic [COORD_W:0]   WIDTH_RND = 33'd75;
  localparam logic [COORD_W-1:0] DIV_K     = 32'd75;
  localparam logic [COORD_W-1:0] RECIP_K   = 32'd3665038759;
  localparam int                 RECIP_SH  = 38;

  localparam logic [1:0] PT_NA = 2'd0;
  localparam logic [1:0] PT_PA = 2'd1;
  localparam logic [1:0] PT_NB = 2'd2;
  localparam logic [1:0] PT_PB = 2'd3;

  function automatic logic [1:0] shr_need(input logic [D_W-1:0] x);
    logic [1:0] r;
    if (x[D_W-1] == x[D_W-2] && x[D_W-2] == x[D_W-3]) r = 2'd0;
    else if (x[D_W-1] == x[D_W-2]) r = 2'd1;
    else r = 2'd2;
    return r;
  endfunction

  function automatic logic [1:0] max2(input logic [1:0] p, input logic [1:0] q);
    return (p > q) ? p : q;
  endfunction

  function automatic logic [COORD_W-1:0] sat32(input logic [S_W-1:0] x);
    logic [COORD_W-1:0] r;
    if (x[S_W-1] == x[S_W-2] && x[S_W-2] == x[S_W-3]) r = x[COORD_W-1:0];
    else if (x[S_W-1]) r = {1'b1, {(COORD_W-1){1'b0}}};
    else r = {1'b0, {(COORD_W-1){1'b1}}};
    return r;
  endfunction

  // Camera registers.
  logic signed [COORD_W-1:0] cam_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r[0] <= '0;
      cam_r[1] <= '0;
      cam_r[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CAM_X: cam_r[0] <= cfg_wdata;
        CFG_CAM_Y: cam_r[1] <= cfg_wdata;
        CFG_CAM_Z: cam_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline control: one enable for every stage.
  logic           adv;
  logic           take;
  logic [NST-1:0] vld_r, vld_nxt;
  carry_t         carry_r [NST];
  carry_t         carry_nxt [NST];

  logic signed [COORD_W-1:0] in_a [3];
  logic signed [COORD_W-1:0] in_b [3];

  assign in_a[0] = in_data.start_x;
  assign in_a[1] = in_data.start_y;
  assign in_a[2] = in_data.start_z;
  assign in_b[0] = in_data.end_x;
  assign in_b[1] = in_data.end_y;
  assign in_b[2] = in_data.end_z;

  assign in_ready = adv;
  assign vld_nxt  = {vld_r[NST-2:0], in_valid};

  // Arithmetic stage registers.
  logic signed [D_W-1:0]   d0_r [3], d0_nxt [3];
  logic signed [D_W-1:0]   v0_r [3], v0_nxt [3];
  logic signed [VEC_W-1:0] d1_r [3], d1_nxt [3];
  logic signed [VEC_W-1:0] v1_r [3], v1_nxt [3];
  logic [2*COORD_W-1:0]    hp_r, hp_nxt;
  logic signed [PRD_W-1:0] p_r [6], p_nxt [6];
  logic signed [CRS_W-1:0] n_r [3], n_nxt [3];
  logic signed [CRS_W-1:0] n4_r [3];
  logic                    sh_right_r, sh_right_nxt;
  logic [SH_W-1:0]         sh_amt_r, sh_amt_nxt;
  logic signed [VEC_W-1:0] nn_r [3], nn_nxt [3];
  logic signed [PRD_W-1:0] sqr_r [3], sqr_nxt [3];
  logic [SQ_W-1:0]         sum_r, sum_nxt;
  logic [SQ_W-1:0]         sq_x_r [SQ_N], sq_x_nxt [SQ_N];
  logic [REM_W-1:0]        sq_rem_r [SQ_N], sq_rem_nxt [SQ_N];
  logic [LEN_W-1:0]        sq_q_r [SQ_N], sq_q_nxt [SQ_N];
  logic [NUM_W-1:0]        num_r [3], num_nxt [3];
  logic [NUM_W-1:0]        dv_rem_r [DV_N][3], dv_rem_nxt [DV_N][3];
  logic [Q_W-1:0]          dv_q_r [DV_N][3], dv_q_nxt [DV_N][3];
  logic [COORD_W-1:0]      vtx_r [4][3], vtx_nxt [4][3];

  // Combinational helpers.
  logic [1:0]          d_amt, v_amt;
  logic [Q_W-1:0]      q0;
  logic [COORD_W-1:0]  rem_h;
  logic [HALF_W-1:0]   half_fix;
  logic [CRS_W-2:0]    sign_or;
  logic [SH_W-1:0]     msb_w;
  logic                n_zero;
  logic [HN_W-1:0]     hn_nxt [3];
  logic [HN_W-1:0]     hn_mag [3];
  logic [REM_W-1:0]    sq_t_rem [SQ_N];
  logic [REM_W-1:0]    sq_trial [SQ_N];
  logic [NUM_W-1:0]    dv_src [DV_N][3];
  logic [NUM_W-1:0]    dv_trial [DV_N];
  logic [S_W-1:0]      s_vec [3];
  logic [S_W-1:0]      q_ext [3];

  // Front end: differences, range and normal scaling, cross product, squares.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d0_nxt[i] = {in_b[i][COORD_W-1], in_b[i]} - {in_a[i][COORD_W-1], in_a[i]};
      v0_nxt[i] = {in_a[i][COORD_W-1], in_a[i]} - {cam_r[i][COORD_W-1], cam_r[i]};
    end

    d_amt = max2(max2(shr_need(d0_r[0]), shr_need(d0_r[1])), shr_need(d0_r[2]));
    v_amt = max2(max2(shr_need(v0_r[0]), shr_need(v0_r[1])), shr_need(v0_r[2]));
    for (int i = 0; i < 3; i++) begin
      d1_nxt[i] = VEC_W'(d0_r[i] >>> d_amt);
      v1_nxt[i] = VEC_W'(v0_r[i] >>> v_amt);
    end
    hp_nxt = carry_r[0].half * RECIP_K;

    p_nxt[0] = d1_r[1] * v1_r[2];
    p_nxt[1] = d1_r[2] * v1_r[1];
    p_nxt[2] = d1_r[2] * v1_r[0];
    p_nxt[3] = d1_r[0] * v1_r[2];
    p_nxt[4] = d1_r[0] * v1_r[1];
    p_nxt[5] = d1_r[1] * v1_r[0];
    q0       = hp_r[2*COORD_W-1-:Q_W];
    rem_h    = carry_r[ST_SHR].half - COORD_W'(q0) * DIV_K;
    half_fix = (rem_h >= DIV_K) ? HALF_W'(q0 + 1'b1) : HALF_W'(q0);

    n_nxt[0] = CRS_W'(p_r[0]) - CRS_W'(p_r[1]);
    n_nxt[1] = CRS_W'(p_r[2]) - CRS_W'(p_r[3]);
    n_nxt[2] = CRS_W'(p_r[4]) - CRS_W'(p_r[5]);

    // Signed width of the widest normal component sets the scaling shift
    // that brings it into [-2^30, 2^30) but not into [-2^29, 2^29).
    sign_or = '0;
    for (int i = 0; i < 3; i++) begin
      sign_or = sign_or | (n_r[i][CRS_W-2:0] ^ {(CRS_W-1){n_r[i][CRS_W-1]}});
    end
    msb_w = SH_W'(1);
    for (int b = 0; b < CRS_W - 1; b++) begin
      if (sign_or[b]) msb_w = SH_W'(b + 2);
    end
    sh_right_nxt = (msb_w > SH_W'(VEC_W));
    sh_amt_nxt   = sh_right_nxt ? msb_w - SH_W'(VEC_W) : SH_W'(VEC_W) - msb_w;
    n_zero       = (n_r[0] == '0) && (n_r[1] == '0) && (n_r[2] == '0);

    for (int i = 0; i < 3; i++) begin
      nn_nxt[i]  = sh_right_r ? VEC_W'(n4_r[i] >>> sh_amt_r) : VEC_W'(n4_r[i] <<< sh_amt_r);
      sqr_nxt[i] = nn_r[i] * nn_r[i];
      hn_nxt[i]  = HN_W'(nn_r[i] * $signed({1'b0, carry_r[ST_NRM].half[HALF_W-1:0]}));
    end
    sum_nxt = SQ_W'(sqr_r[0]) + SQ_W'(sqr_r[1]) + SQ_W'(sqr_r[2]);
  end

  // Square root, one result bit per stage.
  always_comb begin
    for (int j = 0; j < SQ_N; j++) begin
      if (j == 0) begin
        sq_t_rem[j] = {{(REM_W-2){1'b0}}, sum_r[SQ_W-1-:2]};
        sq_trial[j] = REM_W'(3'b001);
        sq_x_nxt[j] = {sum_r[SQ_W-3:0], 2'b00};
        sq_q_nxt[j] = {{(LEN_W-1){1'b0}}, (sq_t_rem[j] >= sq_trial[j])};
      end else begin
        sq_t_rem[j] = {sq_rem_r[j-1][REM_W-3:0], sq_x_r[j-1][SQ_W-1-:2]};
        sq_trial[j] = REM_W'({sq_q_r[j-1], 2'b01});
        sq_x_nxt[j] = {sq_x_r[j-1][SQ_W-3:0], 2'b00};
        sq_q_nxt[j] = {sq_q_r[j-1][LEN_W-2:0], (sq_t_rem[j] >= sq_trial[j])};
      end
      sq_rem_nxt[j] = (sq_t_rem[j] >= sq_trial[j]) ? sq_t_rem[j] - sq_trial[j] : sq_t_rem[j];
    end
  end

  // Rounded numerators and the long divider, three lanes.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hn_mag[i]  = carry_r[ST_NUM-1].hn[i][HN_W-1] ? (~carry_r[ST_NUM-1].hn[i] + 1'b1)
                                                    : carry_r[ST_NUM-1].hn[i];
      num_nxt[i] = NUM_W'(hn_mag[i]) + NUM_W'(sq_q_r[SQ_N-1] >> 1);
    end
    for (int k = 0; k < DV_N; k++) begin
      dv_trial[k] = NUM_W'(carry_r[ST_DV0+k-1].len) << (DV_N - 1 - k);
      for (int i = 0; i < 3; i++) begin
        if (k == 0) begin
          dv_src[k][i]   = num_r[i];
          dv_q_nxt[k][i] = {{(Q_W-1){1'b0}}, (dv_src[k][i] >= dv_trial[k])};
        end else begin
          dv_src[k][i]   = dv_rem_r[k-1][i];
          dv_q_nxt[k][i] = {dv_q_r[k-1][i][Q_W-2:0], (dv_src[k][i] >= dv_trial[k])};
        end
        dv_rem_nxt[k][i] = (dv_src[k][i] >= dv_trial[k]) ? dv_src[k][i] - dv_trial[k]
                                                          : dv_src[k][i];
      end
    end
  end

  // Corner points: endpoint plus or minus the shift, saturated.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_ext[i] = S_W'(dv_q_r[DV_N-1][i]);
      if (carry_r[ST_VTX-1].degen) s_vec[i] = '0;
      else if (carry_r[ST_VTX-1].neg[i]) s_vec[i] = ~q_ext[i] + 1'b1;
      else s_vec[i] = q_ext[i];
      vtx_nxt[PT_NA][i] = sat32(S_W'($signed(carry_r[ST_VTX-1].pt_a[i])) - s_vec[i]);
      vtx_nxt[PT_PA][i] = sat32(S_W'($signed(carry_r[ST_VTX-1].pt_a[i])) + s_vec[i]);
      vtx_nxt[PT_NB][i] = sat32(S_W'($signed(carry_r[ST_VTX-1].pt_b[i])) - s_vec[i]);
      vtx_nxt[PT_PB][i] = sat32(S_W'($signed(carry_r[ST_VTX-1].pt_b[i])) + s_vec[i]);
    end
  end

  // Side record: shifted along, with fields filled in where they are made.
  always_comb begin
    carry_nxt[0] = '0;
    for (int i = 0; i < 3; i++) begin
      carry_nxt[0].pt_a[i] = in_a[i];
      carry_nxt[0].pt_b[i] = in_b[i];
    end
    carry_nxt[0].color = in_data.color;
    carry_nxt[0].half  = COORD_W'(({1'b0, in_data.raw_width} + WIDTH_RND) >> 1);
    carry_nxt[0].degen = (in_b[0] == in_a[0]) && (in_b[1] == in_a[1]) && (in_b[2] == in_a[2]);
    for (int k = 1; k < NST; k++) begin
      carry_nxt[k] = carry_r[k-1];
    end
    carry_nxt[ST_PRD].half  = COORD_W'(half_fix);
    carry_nxt[ST_ENC].degen = carry_r[ST_CRS].degen | n_zero;
    for (int i = 0; i < 3; i++) begin
      carry_nxt[ST_SQR].hn[i]  = hn_nxt[i];
      carry_nxt[ST_NUM].neg[i] = carry_r[ST_NUM-1].hn[i][HN_W-1];
    end
    carry_nxt[ST_NUM].len = sq_q_r[SQ_N-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      carry_r    <= carry_nxt;
      d0_r       <= d0_nxt;
      v0_r       <= v0_nxt;
      d1_r       <= d1_nxt;
      v1_r       <= v1_nxt;
      hp_r       <= hp_nxt;
      p_r        <= p_nxt;
      n_r        <= n_nxt;
      n4_r       <= n_r;
      sh_right_r <= sh_right_nxt;
      sh_amt_r   <= sh_amt_nxt;
      nn_r       <= nn_nxt;
      sqr_r      <= sqr_nxt;
      sum_r      <= sum_nxt;
      sq_x_r     <= sq_x_nxt;
      sq_rem_r   <= sq_rem_nxt;
      sq_q_r     <= sq_q_nxt;
      num_r      <= num_nxt;
      dv_rem_r   <= dv_rem_nxt;
      dv_q_r     <= dv_q_nxt;
      vtx_r      <= vtx_nxt;
    end
  end

  // Output serialiser: six words per segment from the four corner points.
  logic               ser_vld_r, ser_vld_nxt;
  logic [2:0]         ser_slot_r, ser_slot_nxt;
  logic [COORD_W-1:0] ser_pt_r [4][3];
  logic [COORD_W-1:0] ser_color_r;
  logic               ser_degen_r;
  logic [1:0]         pt_sel;

  assign take = !ser_vld_r || (out_ready && ser_slot_r == SLOT_LAST);
  assign adv  = !vld_r[ST_VTX] || take;

  always_comb begin
    ser_vld_nxt  = ser_vld_r;
    ser_slot_nxt = ser_slot_r;
    if (take) begin
      ser_vld_nxt  = vld_r[ST_VTX];
      ser_slot_nxt = '0;
    end else if (out_ready) begin
      ser_slot_nxt = ser_slot_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_vld_r  <= 1'b0;
      ser_slot_r <= '0;
    end else begin
      ser_vld_r  <= ser_vld_nxt;
      ser_slot_r <= ser_slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ser_pt_r    <= vtx_r;
      ser_color_r <= carry_r[ST_VTX].color;
      ser_degen_r <= carry_r[ST_VTX].degen;
    end
  end

  // Triangle list order A1, A2, B1, A2, B2, B1.
  always_comb begin
    case (ser_slot_r)
      3'd0:    pt_sel = PT_NA;
      3'd1:    pt_sel = PT_PA;
      3'd2:    pt_sel = PT_NB;
      3'd3:    pt_sel = PT_PA;
      3'd4:    pt_sel = PT_PB;
      3'd5:    pt_sel = PT_NB;
      default: pt_sel = PT_NA;
    endcase
  end

  assign out_valid             = ser_vld_r;
  assign out_data.vertex_x     = ser_pt_r[pt_sel][0];
  assign out_data.vertex_y     = ser_pt_r[pt_sel][1];
  assign out_data.vertex_z     = ser_pt_r[pt_sel][2];
  assign out_data.vertex_color = ser_color_r;
  assign out_data.corner_slot  = ser_slot_r;
  assign out_data.degenerate   = ser_degen_r;
  assign out_data.last         = (ser_slot_r == SLOT_LAST);

  // An empty serialiser must never hold the pipeline back.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !ser_vld_r |-> in_ready)
    else $error("pipeline stalled with an empty serialiser");

  // A taken word that is not the last moves the slot on by one.
  a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last) |=> (ser_slot_r == $past(ser_slot_r) + 3'd1))
    else $error("corner slot did not advance");

  // After the last word the next segment starts at slot zero.
  a_slot_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last) |=> (ser_slot_r == 3'd0))
    else $error("corner slot did not restart");

  // The slot counter never runs past the end of the list.
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    ser_vld_r |-> (ser_slot_r <= SLOT_LAST))
    else $error("corner slot out of range");

endmodule
